@@ hdl/hsvpa_pkg.sv @@
// Shared types and constants for the HSV to premultiplied ARGB converter.
package hsvpa_pkg;

    localparam int CHAN_W  = 8;
    localparam int PIXEL_W = 32;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    // Hue sectors, named after the primary and secondary colors they span.
    localparam logic [2:0] SEC_RED_YEL = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG = 3'd4;

    // Load enables of the back pipeline stages that the channel units own.
    typedef struct packed {
        logic en4;
        logic en5;
        logic en6;
    } chan_ctl_t;

endpackage

@@ hdl/hsvpa_in_if.sv @@
// Input channel carrying one HSV plus alpha word.
interface hsvpa_in_if #(
    parameter int FRAC_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [FRAC_BITS-1:0] hue;
    logic [FRAC_BITS:0]   saturation;
    logic [FRAC_BITS:0]   brightness;
    logic [FRAC_BITS:0]   opacity;

    modport source (output valid, hue, saturation, brightness, opacity, input ready);
    modport sink   (input valid, hue, saturation, brightness, opacity, output ready);
endinterface

@@ hdl/hsvpa_out_if.sv @@
// Output channel carrying one packed ARGB pixel word.
interface hsvpa_out_if;
    logic                         valid;
    logic                         ready;
    logic [hsvpa_pkg::PIXEL_W-1:0] pixel;

    modport source (output valid, pixel, input ready);
    modport sink   (input valid, pixel, output ready);
endinterface

@@ hdl/hsvpa_chan.sv @@
// One color channel: value times factor, times alpha, scaled to 8 bits and saturated.
module hsvpa_chan #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  hsvpa_pkg::chan_ctl_t          ctl,
    input  logic signed [FRAC_BITS+2:0]   k,
    input  logic [FRAC_BITS:0]            v,
    input  logic [FRAC_BITS:0]            a,
    output logic [hsvpa_pkg::CHAN_W-1:0]  chan
);
    localparam int W      = FRAC_BITS + 1;
    localparam int TERM_W = FRAC_BITS + 2;
    localparam int X1_W   = TERM_W + W;
    localparam int Y_W    = X1_W + 8;

    logic              k_pos;
    logic [2*W-1:0]    prod;
    logic [TERM_W-1:0] term_next, term_reg;
    logic [W-1:0]      a_reg;
    logic [X1_W-1:0]   x1_next, x1_reg;
    logic [Y_W-1:0]    y;
    logic [Y_W-1:0]    half;
    logic [10:0]       x;
    logic [hsvpa_pkg::CHAN_W-1:0] chan_next, chan_reg;

    // Factors never exceed 1.0, so a positive factor fits in W bits.
    always_comb
    begin
        k_pos     = !k[FRAC_BITS+2] && (k != '0);
        prod      = {{W{1'b0}}, v} * {{W{1'b0}}, k[W-1:0]};
        term_next = k_pos ? prod[2*W-1:FRAC_BITS] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en4)
        begin
            term_reg <= term_next;
            a_reg    <= a;
        end
    end

    assign x1_next = {{W{1'b0}}, term_reg} * {{TERM_W{1'b0}}, a_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.en5)
        begin
            x1_reg <= x1_next;
        end
    end

    // Times 255 as a shift and subtract, then round half up and drop 2F bits.
    always_comb
    begin
        half      = Y_W'(1) << (2*FRAC_BITS - 1);
        y         = {x1_reg, 8'b0} - {8'b0, x1_reg} + half;
        x         = y[Y_W-1:2*FRAC_BITS];
        chan_next = (x[10:8] != 3'b0) ? hsvpa_pkg::CHAN_MAX : x[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en6)
        begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

@@ hdl/hsv_to_premultiplied_argb_top.sv @@
// Top level of the HSV plus alpha to premultiplied ARGB pixel converter.
//
// The hsv channel takes one word of hue (Q0.F, wraps), saturation,
// brightness and opacity (Q1.F each). The argb channel returns one packed
// pixel word per input: alpha in 31:24, then premultiplied red, green, blue.
// A word is moved at a clock edge where valid and ready are both high.
//
// The datapath is a six stage pipeline: hue times six and alpha scaling,
// the s*f and s*(1-f) multipliers, factor forming and sector selection,
// value times factor, times alpha, and the times-255 rounding with
// saturation. The last stage is the output register. One word per cycle
// is sustained while argb.ready stays high.
//
// Each stage has its own valid bit and moves forward when the stage after
// it is empty or moving, so bubbles close up while the receiver stalls and
// hsv keeps accepting until every stage is full. Reset empties the pipeline;
// data registers are not reset.
module hsv_to_premultiplied_argb_top #(
    parameter int FRAC_BITS = 16
) (
    input logic              clk,
    input logic              rst_n,
    hsvpa_in_if.sink         hsv,
    hsvpa_out_if.source      argb
);
    localparam int W      = FRAC_BITS + 1;
    localparam int K_W    = FRAC_BITS + 3;
    localparam int STAGES = 6;
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] en;
    hsvpa_pkg::chan_ctl_t ctl;

    // Stage 1 signals.
    logic [FRAC_BITS+2:0]  h6;
    logic [W+7:0]          a255;
    logic [8:0]            ai;
    logic [2:0]            sec1_reg;
    logic [FRAC_BITS-1:0]  f1_reg;
    logic [W-1:0]          s1_reg, v1_reg, a1_reg;
    logic [7:0]            alpha_next, alpha1_reg;

    // Stage 2 signals.
    logic [2*W-1:0]        sf_prod, sf1_prod;
    logic [W-1:0]          one_minus_f;
    logic [2:0]            sec2_reg;
    logic [W-1:0]          s2_reg, v2_reg, a2_reg, sf2_reg, sf12_reg;
    logic [7:0]            alpha2_reg;

    // Stage 3 signals.
    logic signed [K_W-1:0] k_one, kp, kq, kt;
    logic signed [K_W-1:0] kr_next, kg_next, kb_next;
    logic signed [K_W-1:0] kr_reg, kg_reg, kb_reg;
    logic [W-1:0]          v3_reg, a3_reg;
    logic [7:0]            alpha3_reg, alpha4_reg, alpha5_reg, alpha6_reg;

    logic [hsvpa_pkg::CHAN_W-1:0] red, green, blue;

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || argb.ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        ctl.en4 = en[3];
        ctl.en5 = en[4];
        ctl.en6 = en[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= hsv.valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign hsv.ready = en[0];

    // Stage 1: sector and fraction of the hue, and the final alpha byte.
    always_comb
    begin
        h6         = {3'b0, hsv.hue} * (FRAC_BITS+3)'(6);
        a255       = {hsv.opacity, 8'b0} - {8'b0, hsv.opacity}
                     + ((W+8)'(1) << (FRAC_BITS - 1));
        ai         = a255[W+7:FRAC_BITS];
        alpha_next = ai[8] ? hsvpa_pkg::CHAN_MAX : ai[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sec1_reg   <= h6[FRAC_BITS+2:FRAC_BITS];
            f1_reg     <= h6[FRAC_BITS-1:0];
            s1_reg     <= hsv.saturation;
            v1_reg     <= hsv.brightness;
            a1_reg     <= hsv.opacity;
            alpha1_reg <= alpha_next;
        end
    end

    // Stage 2: s*f and s*(1-f), floored back to Q.F.
    always_comb
    begin
        one_minus_f = ONE - {1'b0, f1_reg};
        sf_prod     = {{W{1'b0}}, s1_reg} * {{(W+1){1'b0}}, f1_reg};
        sf1_prod    = {{W{1'b0}}, s1_reg} * {{W{1'b0}}, one_minus_f};
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sec2_reg   <= sec1_reg;
            s2_reg     <= s1_reg;
            v2_reg     <= v1_reg;
            a2_reg     <= a1_reg;
            sf2_reg    <= sf_prod[FRAC_BITS+W-1:FRAC_BITS];
            sf12_reg   <= sf1_prod[FRAC_BITS+W-1:FRAC_BITS];
            alpha2_reg <= alpha1_reg;
        end
    end

    // Stage 3: the p, q, t factors and their routing by sector.
    always_comb
    begin
        k_one = $signed({2'b0, ONE});
        kp    = k_one - $signed({2'b0, s2_reg});
        kq    = k_one - $signed({2'b0, sf2_reg});
        kt    = k_one - $signed({2'b0, sf12_reg});
        case (sec2_reg)
            hsvpa_pkg::SEC_RED_YEL:
            begin
                kr_next = k_one; kg_next = kt;    kb_next = kp;
            end
            hsvpa_pkg::SEC_YEL_GRN:
            begin
                kr_next = kq;    kg_next = k_one; kb_next = kp;
            end
            hsvpa_pkg::SEC_GRN_CYN:
            begin
                kr_next = kp;    kg_next = k_one; kb_next = kt;
            end
            hsvpa_pkg::SEC_CYN_BLU:
            begin
                kr_next = kp;    kg_next = kq;    kb_next = k_one;
            end
            hsvpa_pkg::SEC_BLU_MAG:
            begin
                kr_next = kt;    kg_next = kp;    kb_next = k_one;
            end
            default:
            begin
                kr_next = k_one; kg_next = kp;    kb_next = kq;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            kr_reg     <= kr_next;
            kg_reg     <= kg_next;
            kb_reg     <= kb_next;
            v3_reg     <= v2_reg;
            a3_reg     <= a2_reg;
            alpha3_reg <= alpha2_reg;
        end
    end

    // Stages 4 to 6 run inside the channel units; alpha rides alongside.
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            alpha4_reg <= alpha3_reg;
        end
        if (en[4])
        begin
            alpha5_reg <= alpha4_reg;
        end
        if (en[5])
        begin
            alpha6_reg <= alpha5_reg;
        end
    end

    hsvpa_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
        .clk  (clk),
        .ctl  (ctl),
        .k    (kr_reg),
        .v    (v3_reg),
        .a    (a3_reg),
        .chan (red)
    );

    hsvpa_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
        .clk  (clk),
        .ctl  (ctl),
        .k    (kg_reg),
        .v    (v3_reg),
        .a    (a3_reg),
        .chan (green)
    );

    hsvpa_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
        .clk  (clk),
        .ctl  (ctl),
        .k    (kb_reg),
        .v    (v3_reg),
        .a    (a3_reg),
        .chan (blue)
    );

    assign argb.valid = vld_reg[STAGES-1];
    assign argb.pixel = {alpha6_reg, red, green, blue};

endmodule
